// ===== sv/wgc_pkg.sv =====
// Package for the wifi glyph coverage pipeline: geometry constants,
// register indexes, pipeline widths and small helper functions.
// No dependencies.
package wgc_pkg;

  localparam int ICON_WIDTH    = 24;
  localparam int ICON_HEIGHT   = 24;
  localparam int FRACTION_BITS = 4;

  localparam int UNIT_ONE  = 1 << FRACTION_BITS;
  localparam int FULL_HALF = 2 << FRACTION_BITS;
  localparam int ORG_X     = (ICON_WIDTH * UNIT_ONE) / 2;
  localparam int ORG_Y     = (ICON_HEIGHT - 2) * UNIT_ONE;
  localparam int CTR_Y     = (ICON_HEIGHT * UNIT_ONE) / 2;
  localparam int COS45_Q17 = 92682;
  localparam int HALF_LEN  = (ICON_HEIGHT * FULL_HALF * 62 + 50) / 100;

  // Square root operand width and number of root bits (one per stage).
  localparam int SQ_W    = 24;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int LVL_W   = FRACTION_BITS + 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ELEMENT_MASK = 3'd0;
  localparam logic [2:0] CFG_SLASH_ON     = 3'd1;
  localparam logic [2:0] CFG_ARC_ONE      = 3'd2;
  localparam logic [2:0] CFG_ARC_TWO      = 3'd3;
  localparam logic [2:0] CFG_ARC_THREE    = 3'd4;
  localparam logic [2:0] CFG_DOT_RADIUS   = 3'd5;
  localparam logic [2:0] CFG_STROKE       = 3'd6;
  localparam logic [2:0] CFG_FAN_SLOPE    = 3'd7;

  // Clamp a signed level in half units to 0..FULL_HALF.
  function automatic logic [LVL_W-1:0] clamp_level(input logic signed [14:0] v);
    logic [LVL_W-1:0] res;
    if (v < 15'sd0) begin
      res = '0;
    end else if (v > 15'(FULL_HALF)) begin
      res = LVL_W'(FULL_HALF);
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

  // Stroke band level: UNIT_ONE - |span| + stroke, clamped.
  function automatic logic [LVL_W-1:0] band_level(input logic signed [14:0] span,
                                                   input logic [7:0] stroke);
    logic signed [14:0] mag;
    mag = (span < 15'sd0) ? -span : span;
    return clamp_level(15'(UNIT_ONE) - mag + $signed({7'b0, stroke}));
  endfunction

endpackage

// ===== sv/wifi_glyph_coverage.sv =====
// Top level of the wifi glyph coverage pipeline: configuration registers,
// coordinate math, two pipelined square roots and the level combine.
// Depends on wgc_pkg.
//
//  channel | direction | ports                               | handshake
//  in      | input     | in_pixel_x, in_pixel_y              | in_valid / in_stall
//  out     | output    | out_coverage                        | out_valid / out_stall
//  cfg     | input     | cfg_index, cfg_data                 | cfg_valid / cfg_ready
//
// One pixel enters per clock while the pipeline is not stalled; each result
// passes six geometry stages, the twelve one-bit-per-stage
// square root stages and three combine stages.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. When a result is waiting and the output is stalled the
// whole pipeline holds, so in_stall follows out_stall while a result is waiting.
module wifi_glyph_coverage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] in_pixel_x,
  input  logic [9:0] in_pixel_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_coverage,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int NSTG = 21;

  logic [3:0] element_mask_r;
  logic       slash_on_r;
  logic [9:0] arc_one_r, arc_two_r, arc_three_r;
  logic [7:0] dot_radius_r, stroke_r, fan_slope_r;

  logic            en;
  logic [NSTG-1:0] vld_r;

  assign en        = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_mask_r <= 4'd15;
      slash_on_r     <= 1'b0;
      arc_one_r      <= 10'd64;
      arc_two_r      <= 10'd128;
      arc_three_r    <= 10'd192;
      dot_radius_r   <= 8'd24;
      stroke_r       <= 8'd24;
      fan_slope_r    <= 8'd181;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wgc_pkg::CFG_ELEMENT_MASK: element_mask_r <= cfg_data[3:0];
        wgc_pkg::CFG_SLASH_ON:     slash_on_r     <= cfg_data[0];
        wgc_pkg::CFG_ARC_ONE:      arc_one_r      <= cfg_data;
        wgc_pkg::CFG_ARC_TWO:      arc_two_r      <= cfg_data;
        wgc_pkg::CFG_ARC_THREE:    arc_three_r    <= cfg_data;
        wgc_pkg::CFG_DOT_RADIUS:   dot_radius_r   <= cfg_data[7:0];
        wgc_pkg::CFG_STROKE:       stroke_r       <= cfg_data[7:0];
        wgc_pkg::CFG_FAN_SLOPE:    fan_slope_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 0: input capture.
  logic [9:0] x0_r, y0_r;

  // Stage 1: offsets from the fan origin and rotated-axis magnitudes.
  logic signed [10:0] dx1_r, dy1_r;
  logic [10:0]        su1_r, sd1_r;
  logic signed [11:0] cx_sum, cy_dif;
  logic signed [10:0] cx, cy;

  assign cx     = $signed({1'b0, x0_r}) - 11'(wgc_pkg::ORG_X);
  assign cy     = $signed({1'b0, y0_r}) - 11'(wgc_pkg::CTR_Y);
  assign cx_sum = 12'(cx) + 12'(cy);
  assign cy_dif = 12'(cy) - 12'(cx);

  // Stage 2: squares, slope square and rotation products.
  logic [19:0] dxs2_r, dys2_r;
  logic        dyn2_r;
  logic [15:0] fsq2_r;
  logic [11:0] rx2_r, ry2_r;
  logic signed [21:0] dxp, dyp;
  logic [27:0] rxp, ryp;

  assign dxp = dx1_r * dx1_r;
  assign dyp = dy1_r * dy1_r;
  assign rxp = 28'(su1_r) * 28'(wgc_pkg::COS45_Q17) + 28'd32768;
  assign ryp = 28'(sd1_r) * 28'(wgc_pkg::COS45_Q17) + 28'd32768;

  // Stage 3: squared radius and slash offset along the stroke.
  logic [20:0] rsq3_r;
  logic [19:0] dys3_r;
  logic        dyn3_r;
  logic [15:0] fsq3_r;
  logic [11:0] rx3_r, qy3_r;

  // Stage 4: wedge product and slash squares.
  logic [36:0] wp4_r;
  logic [20:0] rsq4_r;
  logic [19:0] dys4_r;
  logic        dyn4_r;
  logic [23:0] rxs4_r, qys4_r;

  // Stage 5 feeds the square roots: index 0 of the root arrays.
  logic [wgc_pkg::SQ_W-1:0]   rad_rem_r  [0:wgc_pkg::ROOT_W];
  logic [wgc_pkg::ROOT_W-1:0] rad_root_r [0:wgc_pkg::ROOT_W];
  logic [wgc_pkg::SQ_W-1:0]   sl_rem_r   [0:wgc_pkg::ROOT_W];
  logic [wgc_pkg::ROOT_W-1:0] sl_root_r  [0:wgc_pkg::ROOT_W];
  logic                       wok_r      [0:wgc_pkg::ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= in_pixel_x;
      y0_r   <= in_pixel_y;

      dx1_r  <= $signed({1'b0, x0_r}) - 11'(wgc_pkg::ORG_X);
      dy1_r  <= $signed({1'b0, y0_r}) - 11'(wgc_pkg::ORG_Y);
      su1_r  <= cx_sum[11] ? 11'(-cx_sum) : cx_sum[10:0];
      sd1_r  <= cy_dif[11] ? 11'(-cy_dif) : cy_dif[10:0];

      dxs2_r <= dxp[19:0];
      dys2_r <= dyp[19:0];
      dyn2_r <= (dy1_r <= 11'sd0);
      fsq2_r <= 16'(fan_slope_r) * 16'(fan_slope_r);
      rx2_r  <= rxp[27:16];
      ry2_r  <= ryp[27:16];

      rsq3_r <= 21'(dxs2_r) + 21'(dys2_r);
      dys3_r <= dys2_r;
      dyn3_r <= dyn2_r;
      fsq3_r <= fsq2_r;
      rx3_r  <= rx2_r;
      qy3_r  <= (ry2_r > 12'(wgc_pkg::HALF_LEN)) ? ry2_r - 12'(wgc_pkg::HALF_LEN) : '0;

      wp4_r  <= 37'(fsq3_r) * 37'(rsq3_r);
      rsq4_r <= rsq3_r;
      dys4_r <= dys3_r;
      dyn4_r <= dyn3_r;
      rxs4_r <= 24'(rx3_r) * 24'(rx3_r);
      qys4_r <= 24'(qy3_r) * 24'(qy3_r);

      // The wedge is tested without a root: (256*(-dy))^2 >= slope^2 * r^2.
      wok_r[0]      <= dyn4_r && ({1'b0, dys4_r, 16'b0} >= wp4_r);
      rad_rem_r[0]  <= {1'b0, rsq4_r, 2'b00};
      rad_root_r[0] <= '0;
      sl_rem_r[0]   <= rxs4_r + qys4_r;
      sl_root_r[0]  <= '0;
    end
  end

  // One root bit per stage: compare the remainder with (2*root+bit)*bit.
  for (genvar k = 0; k < wgc_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int B = wgc_pkg::ROOT_W - 1 - k;
    logic [wgc_pkg::SQ_W+1:0]   rad_try, sl_try;
    logic [wgc_pkg::SQ_W-1:0]   rad_rem_nxt, sl_rem_nxt;
    logic [wgc_pkg::ROOT_W-1:0] rad_root_nxt, sl_root_nxt;

    always_comb begin
      rad_try = ((wgc_pkg::SQ_W+2)'(rad_root_r[k]) << (B + 1))
              | ((wgc_pkg::SQ_W+2)'(1) << (2 * B));
      sl_try  = ((wgc_pkg::SQ_W+2)'(sl_root_r[k]) << (B + 1))
              | ((wgc_pkg::SQ_W+2)'(1) << (2 * B));
      if ((wgc_pkg::SQ_W+2)'(rad_rem_r[k]) >= rad_try) begin
        rad_rem_nxt  = rad_rem_r[k] - rad_try[wgc_pkg::SQ_W-1:0];
        rad_root_nxt = rad_root_r[k] | (wgc_pkg::ROOT_W'(1) << B);
      end else begin
        rad_rem_nxt  = rad_rem_r[k];
        rad_root_nxt = rad_root_r[k];
      end
      if ((wgc_pkg::SQ_W+2)'(sl_rem_r[k]) >= sl_try) begin
        sl_rem_nxt  = sl_rem_r[k] - sl_try[wgc_pkg::SQ_W-1:0];
        sl_root_nxt = sl_root_r[k] | (wgc_pkg::ROOT_W'(1) << B);
      end else begin
        sl_rem_nxt  = sl_rem_r[k];
        sl_root_nxt = sl_root_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_rem_r[k+1]  <= rad_rem_nxt;
        rad_root_r[k+1] <= rad_root_nxt;
        sl_rem_r[k+1]   <= sl_rem_nxt;
        sl_root_r[k+1]  <= sl_root_nxt;
        wok_r[k+1]      <= wok_r[k];
      end
    end
  end

  // Level stage: one clamped level per element, zero when disabled and, for the arcs, outside the wedge.
  logic [wgc_pkg::LVL_W-1:0] lv_dot_r, lv_a1_r, lv_a2_r, lv_a3_r, lv_sl_r;
  logic [wgc_pkg::LVL_W-1:0] lv_dot_nxt, lv_a1_nxt, lv_a2_nxt, lv_a3_nxt, lv_sl_nxt;
  logic signed [14:0] r2s, ds;
  logic               wok;

  assign r2s = $signed({3'b0, rad_root_r[wgc_pkg::ROOT_W]});
  assign ds  = $signed({3'b0, sl_root_r[wgc_pkg::ROOT_W]});
  assign wok = wok_r[wgc_pkg::ROOT_W];

  always_comb begin
    lv_dot_nxt = element_mask_r[0]
               ? wgc_pkg::clamp_level(15'(wgc_pkg::UNIT_ONE) - r2s
                                      + $signed({6'b0, dot_radius_r, 1'b0}))
               : '0;
    lv_a1_nxt  = (wok && element_mask_r[1])
               ? wgc_pkg::band_level(r2s - $signed({4'b0, arc_one_r, 1'b0}), stroke_r)
               : '0;
    lv_a2_nxt  = (wok && element_mask_r[2])
               ? wgc_pkg::band_level(r2s - $signed({4'b0, arc_two_r, 1'b0}), stroke_r)
               : '0;
    lv_a3_nxt  = (wok && element_mask_r[3])
               ? wgc_pkg::band_level(r2s - $signed({4'b0, arc_three_r, 1'b0}), stroke_r)
               : '0;
    lv_sl_nxt  = slash_on_r ? wgc_pkg::band_level(ds, stroke_r) : '0;
  end

  // Combine stage and output scaling.
  logic [wgc_pkg::LVL_W-1:0] best_r, best_nxt, m01, m23;
  logic [12:0]               scaled;

  assign m01      = (lv_dot_r > lv_a1_r) ? lv_dot_r : lv_a1_r;
  assign m23      = (lv_a2_r > lv_a3_r) ? lv_a2_r : lv_a3_r;
  assign best_nxt = (m01 > m23) ? ((m01 > lv_sl_r) ? m01 : lv_sl_r)
                                : ((m23 > lv_sl_r) ? m23 : lv_sl_r);
  assign scaled   = 13'(best_r) * 13'd255 + 13'(wgc_pkg::FULL_HALF / 2);

  always_ff @(posedge clk) begin
    if (en) begin
      lv_dot_r     <= lv_dot_nxt;
      lv_a1_r      <= lv_a1_nxt;
      lv_a2_r      <= lv_a2_nxt;
      lv_a3_r      <= lv_a3_nxt;
      lv_sl_r      <= lv_sl_nxt;
      best_r       <= best_nxt;
      out_coverage <= scaled[wgc_pkg::FRACTION_BITS+8:wgc_pkg::FRACTION_BITS+1];
    end
  end

endmodule

// ===== sv/wgc_checker.sv =====
// Port-level checks for wifi_glyph_coverage, bound to the top level.
// Depends only on the top level's ports.
module wgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_coverage,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A waiting result holds its value while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coverage))
    else $error("stalled result changed");

  // The pipeline holds exactly when a result waits on a stall.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // The pipeline is empty in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result present right after reset");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind wifi_glyph_coverage wgc_checker u_wgc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_coverage (out_coverage),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
